// File: hw/rtl/indexed_min_heap_queue_macros.svh
// Assertion macros for the indexed min-heap queue.
// Included by the RTL files that carry assertions; no other dependency.
`ifndef INDEXED_MIN_HEAP_QUEUE_MACROS_SVH
`define INDEXED_MIN_HEAP_QUEUE_MACROS_SVH
`ifndef ASSERT_OFF
`define IMHQ_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error("%m failed");
`define IMHQ_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error("%m failed");
`define IMHQ_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error("%m failed");
`else
`define IMHQ_ASSERT(label, cond)
`define IMHQ_ASSERT_IMPL(label, pre, post)
`define IMHQ_ASSERT_NEXT(label, pre, post)
`endif
`endif

// File: hw/rtl/imhq_pkg.sv
// Shared types, codes and sizes of the indexed min-heap queue.
// No dependencies.
package imhq_pkg;
  localparam int CAPACITY  = 256;
  localparam int ID_BITS   = 8;
  localparam int ID_COUNT  = 1 << ID_BITS;
  localparam int SLOT_BITS = $clog2(CAPACITY + 1);

  typedef logic [SLOT_BITS-1:0] slot_t;
  typedef logic [ID_BITS-1:0]   id_t;
  typedef logic signed [31:0]   key_t;
  typedef logic [31:0]          word_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SETKEY = 2'd1,
    CMD_DELMIN = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_PRESENT  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  // controller -> datapath
  typedef enum logic [3:0] {
    OP_NONE,      // idle
    OP_LOAD,      // capture the command, read position entry
    OP_CHECK,     // evaluate status
    OP_INS,       // append new entry, start sift up at count
    OP_SETUP,     // start set key / remove at looked-up slot
    OP_POPRD,     // read root and last slot
    OP_POPWR,     // move last to root, start sift down
    OP_UPRD,      // read parent
    OP_UPSTEP,    // compare and move one level up
    OP_DNRD,      // read both children
    OP_DNSTEP,    // compare and move one level down
    OP_PLACE,     // write the held entry at the current slot
    OP_RESULT     // load result register
  } op_t;

  typedef struct packed {
    op_t op;
  } ctl_t;

  typedef struct packed {
    status_t status;   // check verdict
    logic    up_go;    // sift up moves this level
    logic    dn_go;    // sift down moves this level
    logic    up_dir;   // set key: sift up (else down)
    logic    key_eq;   // set key: equal key, nothing moves
    logic    last_gone;// delete left heap empty
    cmd_t    cmd;
  } sts_t;
endpackage

// File: hw/rtl/imhq_datapath.sv
// Heap memories, position table and sift datapath of the min-heap queue.
// Depends on imhq_pkg and the assertion macros header.
`include "indexed_min_heap_queue_macros.svh"
module imhq_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  imhq_pkg::ctl_t   ctl,
  output imhq_pkg::sts_t   sts,
  input  logic [1:0]       in_cmd,
  input  logic [7:0]       in_id,
  input  logic [31:0]      in_key,
  input  logic [31:0]      in_pl,
  output logic [2:0]       res_status,
  output logic [7:0]       res_id,
  output logic [31:0]      res_key,
  output logic [31:0]      res_pl
);
  import imhq_pkg::*;

  // heap slots 1..CAPACITY; index width covers CAPACITY
  key_t  mkey [CAPACITY+1];
  id_t   mid  [CAPACITY+1];
  word_t mpl  [CAPACITY+1];
  slot_t pos  [ID_COUNT];
  logic [ID_COUNT-1:0] pvalid_r;

  slot_t count_r;
  cmd_t  cmd_r;
  id_t   id_r;
  key_t  nkey_r;
  word_t npl_r;
  // held entry being sifted
  key_t  hkey_r;
  id_t   hid_r;
  word_t hpl_r;
  slot_t slot_r;
  // read data
  key_t  ak_r, bk_r;
  id_t   ai_r, bi_r;
  word_t ap_r, bp_r;
  slot_t pos_rd_r;
  key_t  oldkey_r;
  status_t status_r;
  // entry taken out by a pop, held until the result is loaded
  id_t   pid_r;
  word_t ppl_r;

  logic [SLOT_BITS:0] lchild, rchild;
  logic  has_r;
  logic  take_b;
  key_t  ck;

  assign lchild = {slot_r, 1'b0};
  assign rchild = lchild + 1'b1;
  assign has_r  = rchild <= {1'b0, count_r};
  assign take_b = has_r && (bk_r < ak_r);
  assign ck     = take_b ? bk_r : ak_r;

  always_comb begin
    sts.status    = status_r;
    sts.up_go     = (slot_r > slot_t'(1)) && (hkey_r <= ak_r);
    sts.dn_go     = (lchild <= {1'b0, count_r}) && (ck < hkey_r);
    sts.up_dir    = oldkey_r > nkey_r;
    sts.key_eq    = oldkey_r == nkey_r;
    sts.last_gone = count_r == '0;
    sts.cmd       = cmd_r;
  end

  // memory ports: port A and port B reads, one write
  always_ff @(posedge clk) begin
    slot_t ra, rb;
    ra = slot_r;
    rb = slot_r;
    case (ctl.op)
      OP_UPRD:  ra = slot_r >> 1;
      OP_DNRD: begin
        ra = lchild[SLOT_BITS-1:0];
        rb = (lchild[SLOT_BITS-1:0] == slot_t'(CAPACITY)) ? lchild[SLOT_BITS-1:0]
                                                          : rchild[SLOT_BITS-1:0];
      end
      OP_POPRD: begin
        ra = slot_t'(1);
        rb = count_r;
      end
      default: ;
    endcase
    ak_r <= mkey[ra]; ai_r <= mid[ra]; ap_r <= mpl[ra];
    bk_r <= mkey[rb]; bi_r <= mid[rb]; bp_r <= mpl[rb];
    case (ctl.op)
      OP_UPSTEP: if (sts.up_go) begin
        mkey[slot_r] <= ak_r; mid[slot_r] <= ai_r; mpl[slot_r] <= ap_r;
      end
      OP_DNSTEP: if (sts.dn_go) begin
        mkey[slot_r] <= ck;
        mid[slot_r]  <= take_b ? bi_r : ai_r;
        mpl[slot_r]  <= take_b ? bp_r : ap_r;
      end
      OP_PLACE: begin
        mkey[slot_r] <= hkey_r; mid[slot_r] <= hid_r; mpl[slot_r] <= hpl_r;
      end
      default: ;
    endcase
    pos_rd_r <= pos[id_r];
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_UPSTEP: if (sts.up_go) pos[ai_r] <= slot_r;
      OP_DNSTEP: if (sts.dn_go) pos[take_b ? bi_r : ai_r] <= slot_r;
      OP_PLACE:  pos[hid_r] <= slot_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvalid_r <= '0;
      count_r  <= '0;
    end else begin
      case (ctl.op)
        OP_INS: begin
          pvalid_r[id_r] <= 1'b1;
          count_r <= count_r + 1'b1;
        end
        OP_POPWR: begin
          pvalid_r[ai_r] <= 1'b0;
          count_r <= count_r - 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        cmd_r  <= cmd_t'(in_cmd);
        id_r   <= id_t'(in_id);
        nkey_r <= in_key;
        npl_r  <= in_pl;
      end
      OP_CHECK: begin
        status_r <= ST_OK;
        unique case (cmd_r) inside
          CMD_INSERT:
            if (count_r == slot_t'(CAPACITY)) status_r <= ST_FULL;
            else if (pvalid_r[id_r])          status_r <= ST_PRESENT;
          CMD_SETKEY, CMD_REMOVE:
            if (!pvalid_r[id_r]) status_r <= ST_NOTFOUND;
          CMD_DELMIN:
            if (count_r == '0) status_r <= ST_EMPTY;
          default: ;
        endcase
        slot_r <= pos_rd_r;
      end
      OP_INS: begin
        slot_r <= count_r + 1'b1;
        hkey_r <= nkey_r; hid_r <= id_r; hpl_r <= npl_r;
      end
      OP_SETUP: begin
        // ak_r holds the entry at slot_r (port A read its own slot)
        oldkey_r <= ak_r;
        hkey_r   <= (cmd_r == CMD_REMOVE) ? key_t'(32'h8000_0000) : nkey_r;
        hid_r    <= ai_r; hpl_r <= ap_r;
      end
      OP_POPWR: begin
        pid_r <= ai_r; ppl_r <= ap_r;
        if (cmd_r == CMD_DELMIN) oldkey_r <= ak_r;
        hkey_r <= bk_r; hid_r <= bi_r; hpl_r <= bp_r;
        slot_r <= slot_t'(1);
      end
      OP_UPSTEP: if (sts.up_go) slot_r <= slot_r >> 1;
      OP_DNSTEP: if (sts.dn_go) slot_r <= take_b ? rchild[SLOT_BITS-1:0]
                                                 : lchild[SLOT_BITS-1:0];
      OP_RESULT: begin
        res_status <= status_r;
        if (status_r != ST_OK || cmd_r == CMD_INSERT || cmd_r == CMD_SETKEY) begin
          res_id <= '0; res_key <= '0; res_pl <= '0;
        end else begin
          res_id <= pid_r; res_key <= oldkey_r; res_pl <= ppl_r;
        end
      end
      default: ;
    endcase
  end

  `IMHQ_ASSERT(a_count_cap, count_r <= slot_t'(CAPACITY))
  `IMHQ_ASSERT_NEXT(a_ins_grows, ctl.op == OP_INS, count_r == $past(count_r) + 1'b1)
  `IMHQ_ASSERT_IMPL(a_up_slot, ctl.op == OP_UPSTEP, slot_r != '0)
endmodule

// File: hw/rtl/imhq_ctrl.sv
// Command sequencer of the min-heap queue: handshakes and sift loop control.
// Depends on imhq_pkg and the assertion macros header.
`include "indexed_min_heap_queue_macros.svh"
module imhq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output imhq_pkg::ctl_t ctl,
  input  imhq_pkg::sts_t sts
);
  import imhq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RDPOS, S_CHECK, S_DISP, S_SETUP, S_SETDEC, S_POPRD, S_POPWR,
    S_UPRD, S_UPSTEP, S_DNRD, S_DNSTEP, S_PLACE, S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   remove_pop_r, remove_pop_nxt;

  assign out_valid = out_valid_r;
  // take a new command only in idle; a waiting result sits in its own register
  assign in_stall  = (state_r != S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && out_stall;
    remove_pop_nxt = remove_pop_r;
    ctl.op         = OP_NONE;
    unique case (state_r)
      S_IDLE: if (in_valid && !in_stall) begin
        ctl.op = OP_LOAD; state_nxt = S_RDPOS; remove_pop_nxt = 1'b0;
      end
      S_RDPOS: state_nxt = S_CHECK;          // position read settles
      S_CHECK: begin ctl.op = OP_CHECK; state_nxt = S_DISP; end
      S_DISP: begin
        if (sts.status != ST_OK) state_nxt = S_RESULT;
        else unique case (sts.cmd)
          CMD_INSERT: begin ctl.op = OP_INS; state_nxt = S_UPRD; end
          CMD_DELMIN: state_nxt = S_POPRD;
          default:    state_nxt = S_SETUP;   // read own slot
        endcase
      end
      S_SETUP: begin ctl.op = OP_SETUP; state_nxt = S_SETDEC; end
      S_SETDEC: begin
        // after a pop, sift the moved last entry down unless the heap is empty
        if (remove_pop_r)               state_nxt = sts.last_gone ? S_RESULT : S_DNRD;
        else if (sts.cmd == CMD_REMOVE) state_nxt = S_UPRD;
        else if (sts.key_eq)            state_nxt = S_PLACE;
        else if (sts.up_dir)            state_nxt = S_UPRD;
        else                            state_nxt = S_DNRD;
      end
      S_UPRD:   begin ctl.op = OP_UPRD; state_nxt = S_UPSTEP; end
      S_UPSTEP: begin
        ctl.op = OP_UPSTEP;
        state_nxt = sts.up_go ? S_UPRD : S_PLACE;
      end
      S_DNRD:   begin ctl.op = OP_DNRD; state_nxt = S_DNSTEP; end
      S_DNSTEP: begin
        ctl.op = OP_DNSTEP;
        state_nxt = sts.dn_go ? S_DNRD : S_PLACE;
      end
      S_PLACE: begin
        ctl.op = OP_PLACE;
        if (sts.cmd == CMD_REMOVE && !remove_pop_r) begin
          remove_pop_nxt = 1'b1; state_nxt = S_POPRD;
        end else state_nxt = S_RESULT;
      end
      S_POPRD: begin ctl.op = OP_POPRD; state_nxt = S_POPWR; end
      S_POPWR: begin
        ctl.op = OP_POPWR; remove_pop_nxt = 1'b1;
        state_nxt = S_SETDEC;
      end
      S_RESULT: if (!out_valid_r) begin
        ctl.op = OP_RESULT; out_valid_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      remove_pop_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      remove_pop_r <= remove_pop_nxt;
    end
  end

  `IMHQ_ASSERT_IMPL(a_no_accept_busy, state_r != S_IDLE, in_stall)
  `IMHQ_ASSERT_IMPL(a_result_once, ctl.op == OP_RESULT, !out_valid_r)
  `IMHQ_ASSERT_NEXT(a_result_shows, ctl.op == OP_RESULT, out_valid_r)
endmodule

// File: hw/rtl/indexed_min_heap_queue.sv
// Top level of the indexed min-heap priority queue.
// Depends on imhq_pkg, imhq_ctrl and imhq_datapath.
//
// Indexed binary min-heap of up to 256 (id, key, payload) entries with a
// per-id position table. One command is taken at a time: insert, set key,
// delete minimum or remove by id, each returning exactly one status
// transaction. The sift loop walks the heap memory one level at a time,
// first reading the level, then comparing and writing. Remove runs a sift
// to the root, a pop and a sift down. The result sits in its own register,
// so the next command is taken while it waits; that command holds in its
// result step until the previous transaction has left.
module indexed_min_heap_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_item_id,
  input  logic [31:0] in_new_key,
  input  logic [31:0] in_payload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_id,
  output logic [31:0] out_key,
  output logic [31:0] out_payload
);
  import imhq_pkg::*;

  ctl_t ctl;
  sts_t sts;

  imhq_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .ctl, .sts
  );

  imhq_datapath u_dp (
    .clk, .rst_n, .ctl, .sts,
    .in_cmd(in_command), .in_id(in_item_id), .in_key(in_new_key),
    .in_pl(in_payload),
    .res_status(out_status), .res_id(out_id), .res_key(out_key),
    .res_pl(out_payload)
  );
endmodule
